[hw/rtl/clms_pkg.sv]
// Shared types, constants and pin maps for the charlieplexed LED matrix scanner.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package clms_pkg;

    localparam int PIX_W          = 24;
    localparam int SPEAKER_BIT    = 23;
    localparam int ROW_W          = 4;
    localparam int COL_W          = 3;
    localparam int FRAME_DEPTH    = 16;
    localparam int FRAME_IDX_W    = 4;
    localparam int PIN_IDX_W      = 5;
    localparam int DIV_W          = 5;
    localparam int TONE_W         = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int KIND_W         = 2;

    localparam int TICKS_PER_ROW_DEF = 30;

    localparam logic [TONE_W-1:0] TONE_RESET = TONE_W'(100);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOUND_ENABLE = 2'd0,
        REG_TONE_PERIOD  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                   wr_en;
        logic [FRAME_IDX_W-1:0] wr_idx;
        logic [PIN_IDX_W-1:0]   wr_bit;
        logic                   wr_val;
        logic [FRAME_IDX_W-1:0] rd_idx;
    } frame_ctrl_t;

    // Pin driven high to select each scanned row.
    function automatic logic [PIN_IDX_W-1:0] anode_pin(input logic [ROW_W-1:0] r);
        logic [PIN_IDX_W-1:0] p;
        case (r)
            4'd0:    p = 5'd10;
            4'd1:    p = 5'd22;
            4'd2:    p = 5'd18;
            4'd3:    p = 5'd0;
            4'd4:    p = 5'd20;
            4'd5:    p = 5'd17;
            4'd6:    p = 5'd4;
            4'd7:    p = 5'd7;
            4'd8:    p = 5'd5;
            4'd9:    p = 5'd6;
            4'd10:   p = 5'd19;
            4'd11:   p = 5'd16;
            4'd12:   p = 5'd8;
            4'd13:   p = 5'd1;
            4'd14:   p = 5'd9;
            4'd15:   p = 5'd11;
            default: p = 5'd0;
        endcase
        return p;
    endfunction

    // Bit of the frame word that holds the pixel of each row.
    function automatic logic [PIN_IDX_W-1:0] cathode_pin(input logic [ROW_W-1:0] r);
        logic [PIN_IDX_W-1:0] p;
        case (r)
            4'd0:    p = 5'd8;
            4'd1:    p = 5'd9;
            4'd2:    p = 5'd1;
            4'd3:    p = 5'd16;
            4'd4:    p = 5'd19;
            4'd5:    p = 5'd6;
            4'd6:    p = 5'd5;
            4'd7:    p = 5'd11;
            4'd8:    p = 5'd20;
            4'd9:    p = 5'd4;
            4'd10:   p = 5'd17;
            4'd11:   p = 5'd0;
            4'd12:   p = 5'd18;
            4'd13:   p = 5'd22;
            4'd14:   p = 5'd10;
            4'd15:   p = 5'd7;
            default: p = 5'd0;
        endcase
        return p;
    endfunction

endpackage

[hw/rtl/charlieplex_led_matrix_scanner_unit.sv]
// Top level of the charlieplexed LED matrix scanner with square-wave speaker.
// Depends on clms_pkg and instantiates clms_frame_buf.
`timescale 1ns / 1ps
//
//  Channel  Handshake            Payload
//  in       in_valid/in_ready    kind, row, column, pixel_value
//  out      out_valid/out_ready  port_drive, port_direction, pixel_read
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item passes an input register and a result register, which hold it in turn;
// one item per cycle is sustained as long as out_ready stays high.
// The update of counters and one frame word sits between those two registers.
// Reset clears frame buffer, scan counters and latches at once; no clearing pass.
// A stalled result holds the input register, which then holds in_ready low.
// Configuration writes are always accepted.

module charlieplex_led_matrix_scanner_unit #(
    parameter int TICKS_PER_ROW = clms_pkg::TICKS_PER_ROW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [clms_pkg::KIND_W-1:0]         kind,
    input  logic [clms_pkg::ROW_W-1:0]          row,
    input  logic [clms_pkg::COL_W-1:0]          column,
    input  logic                                pixel_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [clms_pkg::PIX_W-1:0]          port_drive,
    output logic [clms_pkg::PIX_W-1:0]          port_direction,
    output logic                                pixel_read,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [clms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clms_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PIX_W  = clms_pkg::PIX_W;
    localparam int DIV_W  = clms_pkg::DIV_W;
    localparam int TONE_W = clms_pkg::TONE_W;
    localparam int ROW_W  = clms_pkg::ROW_W;

    // Input register
    logic                          s1_valid_reg;
    logic [clms_pkg::KIND_W-1:0]   s1_kind_reg;
    logic [ROW_W-1:0]              s1_row_reg;
    logic [clms_pkg::COL_W-1:0]    s1_col_reg;
    logic                          s1_val_reg;
    logic                          s1_fire;

    // Block state
    logic                          sound_enable_reg;
    logic [TONE_W-1:0]             tone_period_reg;
    logic [TONE_W-1:0]             tone_count_reg;
    logic [TONE_W-1:0]             tone_count_next;
    logic                          speaker_reg;
    logic                          speaker_next;
    logic [DIV_W-1:0]              tick_div_reg;
    logic [DIV_W-1:0]              tick_div_next;
    logic [ROW_W-1:0]              scan_row_reg;
    logic [ROW_W-1:0]              scan_row_next;
    logic [PIX_W-1:0]              drive_latch_reg;
    logic [PIX_W-1:0]              drive_latch_next;
    logic [PIX_W-1:0]              dir_latch_reg;
    logic [PIX_W-1:0]              dir_latch_next;

    // Result register
    logic                          out_valid_reg;
    logic [PIX_W-1:0]              port_drive_reg;
    logic [PIX_W-1:0]              port_dir_reg;
    logic                          pixel_read_reg;
    logic                          pixel_read_next;

    logic                          is_tick;
    logic [DIV_W:0]                div_sum;
    logic                          div_wrap;
    logic [clms_pkg::PIN_IDX_W-1:0] bit_idx;
    logic [clms_pkg::FRAME_IDX_W-1:0] word_idx;
    logic [PIX_W-1:0]              rd_word;
    clms_pkg::frame_ctrl_t         fctrl;

    assign s1_fire   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign cfg_ready = 1'b1;

    assign out_valid      = out_valid_reg;
    assign port_drive     = port_drive_reg;
    assign port_direction = port_dir_reg;
    assign pixel_read     = pixel_read_reg;

    assign is_tick  = (s1_kind_reg == clms_pkg::KIND_TICK);
    assign word_idx = {s1_row_reg[ROW_W-1], s1_col_reg};
    assign bit_idx  = clms_pkg::cathode_pin(s1_row_reg);

    always_comb
    begin
        fctrl.wr_en  = s1_fire && (s1_kind_reg == clms_pkg::KIND_WRITE);
        fctrl.wr_idx = word_idx;
        fctrl.wr_bit = bit_idx;
        fctrl.wr_val = s1_val_reg;
        fctrl.rd_idx = is_tick ? scan_row_reg : word_idx;
    end

    clms_frame_buf u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (fctrl),
        .rd_word (rd_word)
    );

    assign div_sum  = {1'b0, tick_div_reg} + (DIV_W+1)'(1);
    assign div_wrap = (div_sum >= (DIV_W+1)'(TICKS_PER_ROW));

    always_comb
    begin
        tone_count_next  = tone_count_reg;
        speaker_next     = speaker_reg;
        tick_div_next    = tick_div_reg;
        scan_row_next    = scan_row_reg;
        drive_latch_next = drive_latch_reg;
        dir_latch_next   = dir_latch_reg;
        pixel_read_next  = 1'b0;
        case (s1_kind_reg)
            clms_pkg::KIND_TICK:
            begin
                if (sound_enable_reg)
                begin
                    if (tone_count_reg != '0)
                    begin
                        tone_count_next = tone_count_reg - TONE_W'(1);
                    end
                    else
                    begin
                        speaker_next    = !speaker_reg;
                        tone_count_next = tone_period_reg;
                    end
                end
                if (div_wrap)
                begin
                    tick_div_next    = '0;
                    drive_latch_next = PIX_W'(1) << clms_pkg::anode_pin(scan_row_reg);
                    dir_latch_next   = rd_word | drive_latch_next
                                     | (PIX_W'(1) << clms_pkg::SPEAKER_BIT);
                    scan_row_next    = scan_row_reg + ROW_W'(1);
                end
                else
                begin
                    tick_div_next = div_sum[DIV_W-1:0];
                end
            end
            clms_pkg::KIND_READ:
            begin
                pixel_read_next = rd_word[bit_idx];
            end
            default:
            begin
                pixel_read_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg <= kind;
            s1_row_reg  <= row;
            s1_col_reg  <= column;
            s1_val_reg  <= pixel_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_enable_reg <= 1'b1;
            tone_period_reg  <= clms_pkg::TONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                clms_pkg::REG_SOUND_ENABLE: sound_enable_reg <= cfg_data[0];
                clms_pkg::REG_TONE_PERIOD:  tone_period_reg  <= cfg_data[TONE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_count_reg  <= clms_pkg::TONE_RESET;
            speaker_reg     <= 1'b0;
            tick_div_reg    <= '0;
            scan_row_reg    <= '0;
            drive_latch_reg <= '0;
            dir_latch_reg   <= '0;
        end
        else if (s1_fire)
        begin
            tone_count_reg  <= tone_count_next;
            speaker_reg     <= speaker_next;
            tick_div_reg    <= tick_div_next;
            scan_row_reg    <= scan_row_next;
            drive_latch_reg <= drive_latch_next;
            dir_latch_reg   <= dir_latch_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            port_drive_reg <= drive_latch_next
                            | (PIX_W'(speaker_next) << clms_pkg::SPEAKER_BIT);
            port_dir_reg   <= dir_latch_next;
            pixel_read_reg <= pixel_read_next;
        end
    end

    // The scan selects at most one anode pin at a time.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(drive_latch_reg))
        else $error("More than one anode pin is driven.");

    // The divider never reaches the wrap value.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_div_reg < DIV_W'(TICKS_PER_ROW))
        else $error("Tick divider out of range.");

    // Once a row is scanned, the anode and speaker pins are outputs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dir_latch_reg != '0) |->
        (dir_latch_reg[clms_pkg::SPEAKER_BIT]
         && ((dir_latch_reg & drive_latch_reg) == drive_latch_reg)))
        else $error("Direction mask misses a driven pin.");

    // A stalled result keeps the waiting item in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("Item lost while the result was stalled.");

    // Only a pixel read reports a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_kind_reg != clms_pkg::KIND_READ)) |=> !pixel_read_reg)
        else $error("Pixel reported on an item that is not a read.");

endmodule

[hw/rtl/clms_frame_buf.sv]
// Frame buffer of the LED matrix: sixteen 24-bit words with single-bit updates.
// Depends on clms_pkg for widths and the control struct.
`timescale 1ns / 1ps

module clms_frame_buf (
    input  logic                               clk,
    input  logic                               rst_n,
    input  clms_pkg::frame_ctrl_t              ctrl,
    output logic [clms_pkg::PIX_W-1:0]         rd_word
);

    logic [clms_pkg::PIX_W-1:0] words_reg [clms_pkg::FRAME_DEPTH];

    assign rd_word = words_reg[ctrl.rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < clms_pkg::FRAME_DEPTH; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else if (ctrl.wr_en)
        begin
            words_reg[ctrl.wr_idx][ctrl.wr_bit] <= ctrl.wr_val;
        end
    end

endmodule
